// ===== hw/rtl/fcp_pkg.sv =====
// shared types and codes for the floor control participant
`default_nettype none

package fcp_pkg;

  typedef enum logic [1:0] {
    ST_IDLE       = 2'd0,
    ST_REQUESTING = 2'd1,
    ST_GRANTED    = 2'd2,
    ST_RELEASING  = 2'd3
  } floor_state_t;

  typedef enum logic [2:0] {
    CMD_LOCAL_REQ   = 3'd0,
    CMD_LOCAL_REL   = 3'd1,
    CMD_REQ_RSP     = 3'd2,
    CMD_REL_RSP     = 3'd3,
    CMD_SRV_STATUS  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    RC_OK       = 3'd0,
    RC_NOTCONN  = 3'd1,
    RC_ALREADY  = 3'd2,
    RC_BUSY     = 3'd3,
    RC_NOFLOOR  = 3'd4,
    RC_SENDFAIL = 3'd5
  } result_code_t;

  typedef enum logic [1:0] {
    SEND_NONE    = 2'd0,
    SEND_REQUEST = 2'd1,
    SEND_RELEASE = 2'd2
  } send_kind_t;

  typedef enum logic [1:0] {
    PRIM_FLOOR_REQ_STATUS = 2'd0,
    PRIM_FLOOR_STATUS     = 2'd1,
    PRIM_ERROR            = 2'd2,
    PRIM_OTHER            = 2'd3
  } prim_kind_t;

  typedef enum logic [2:0] {
    RS_PENDING   = 3'd0,
    RS_ACCEPTED  = 3'd1,
    RS_GRANTED   = 3'd2,
    RS_DENIED    = 3'd3,
    RS_CANCELLED = 3'd4,
    RS_RELEASED  = 3'd5,
    RS_REVOKED   = 3'd6,
    RS_OTHER     = 3'd7
  } req_status_t;

  localparam int unsigned ReqIdW = 16;

  typedef struct packed {
    floor_state_t        fsm_st;
    logic [ReqIdW-1:0]   held_req_id;
    logic                req_id_known;
  } fcp_ctx_t;

  typedef struct packed {
    cmd_t                cmd;
    logic                link_up;
    logic                floor_id_ok;
    logic                transport_err;
    prim_kind_t          prim_kind;
    logic                status_found;
    logic [ReqIdW-1:0]   msg_req_id;
    req_status_t         req_status;
  } fcp_evt_t;

  typedef struct packed {
    result_code_t        result_code;
    send_kind_t          send_kind;
    logic [ReqIdW-1:0]   release_req_id;
    logic                notify_valid;
    logic                notify_granted;
    floor_state_t        floor_state_out;
  } fcp_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fcp_step.sv =====
// next-state and result decision for one floor control event
`default_nettype none

module fcp_step (
  input  fcp_pkg::fcp_evt_t evt,
  input  fcp_pkg::fcp_ctx_t ctx,
  output fcp_pkg::fcp_ctx_t ctx_nxt,
  output fcp_pkg::fcp_res_t res
);
  import fcp_pkg::*;

  // effect of a request status on the current state
  floor_state_t ap_state;
  logic         ap_note;
  logic         ap_granted;

  always_comb begin
    ap_state   = ctx.fsm_st;
    ap_note    = 1'b0;
    ap_granted = 1'b0;
    case (evt.req_status)
      RS_GRANTED: begin
        if (ctx.fsm_st != ST_RELEASING) begin
          ap_state   = ST_GRANTED;
          ap_note    = 1'b1;
          ap_granted = 1'b1;
        end
      end
      RS_PENDING, RS_ACCEPTED: begin
        ap_state = ctx.fsm_st;
      end
      default: begin
        ap_state = ST_IDLE;
        ap_note  = 1'b1;
      end
    endcase
  end

  logic id_match;
  logic id_adopt;
  logic prim_usable;

  assign id_match    = ctx.req_id_known && (evt.msg_req_id == ctx.held_req_id);
  assign id_adopt    = (evt.prim_kind == PRIM_FLOOR_REQ_STATUS)
                       && (ctx.fsm_st == ST_REQUESTING) && !ctx.req_id_known;
  assign prim_usable = (evt.prim_kind == PRIM_FLOOR_REQ_STATUS)
                       || (evt.prim_kind == PRIM_FLOOR_STATUS);

  always_comb begin
    ctx_nxt            = ctx;
    res.result_code    = RC_OK;
    res.send_kind      = SEND_NONE;
    res.release_req_id = '0;
    res.notify_valid   = 1'b0;
    res.notify_granted = 1'b0;
    case (evt.cmd)
      CMD_LOCAL_REQ: begin
        if (!evt.link_up) begin
          res.result_code = RC_NOTCONN;
        end else if (ctx.fsm_st == ST_REQUESTING || ctx.fsm_st == ST_GRANTED) begin
          res.result_code = RC_ALREADY;
        end else if (ctx.fsm_st == ST_RELEASING) begin
          res.result_code = RC_BUSY;
        end else if (!evt.floor_id_ok) begin
          res.result_code = RC_NOFLOOR;
        end else if (evt.transport_err) begin
          res.result_code = RC_SENDFAIL;
        end else begin
          res.send_kind        = SEND_REQUEST;
          ctx_nxt.held_req_id  = '0;
          ctx_nxt.req_id_known = 1'b0;
          ctx_nxt.fsm_st       = ST_REQUESTING;
        end
      end
      CMD_LOCAL_REL: begin
        if (ctx.fsm_st == ST_REQUESTING) begin
          res.result_code = RC_BUSY;
        end else if (ctx.fsm_st == ST_GRANTED) begin
          if (evt.transport_err) begin
            res.result_code = RC_SENDFAIL;
          end else begin
            res.send_kind      = SEND_RELEASE;
            res.release_req_id = ctx.held_req_id;
            res.notify_valid   = 1'b1;
            ctx_nxt.fsm_st     = ST_RELEASING;
          end
        end
      end
      CMD_REQ_RSP: begin
        if (ctx.fsm_st == ST_REQUESTING) begin
          if (evt.transport_err || evt.prim_kind != PRIM_FLOOR_REQ_STATUS
              || !evt.status_found) begin
            ctx_nxt.fsm_st   = ST_IDLE;
            res.notify_valid = 1'b1;
          end else begin
            ctx_nxt.held_req_id  = evt.msg_req_id;
            ctx_nxt.req_id_known = 1'b1;
            ctx_nxt.fsm_st       = ap_state;
            res.notify_valid     = ap_note;
            res.notify_granted   = ap_granted;
          end
        end
      end
      CMD_REL_RSP: begin
        if (ctx.fsm_st == ST_RELEASING) begin
          ctx_nxt.fsm_st = ST_IDLE;
        end
      end
      CMD_SRV_STATUS: begin
        if (prim_usable && ctx.fsm_st != ST_IDLE && evt.status_found
            && (id_match || id_adopt)) begin
          // unknown id is taken over once while the request is outstanding
          if (!id_match) begin
            ctx_nxt.held_req_id  = evt.msg_req_id;
            ctx_nxt.req_id_known = 1'b1;
          end
          ctx_nxt.fsm_st     = ap_state;
          res.notify_valid   = ap_note;
          res.notify_granted = ap_granted;
        end
      end
      default: begin
        ctx_nxt = ctx;
      end
    endcase
    res.floor_state_out = ctx_nxt.fsm_st;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/floor_control_participant_fsm.sv =====
// top level: input stage, floor context register and result register
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall  | event fields, one per port
//  out_    | output    | out_valid / out_stall| result fields, one per port
//
// one event per cycle sustained while out_stall is low; each result passes
// through the input register, then the result register, before it is
// offered on the output
// the floor context register updates in the cycle the event moves to the
// result register, so the next event always sees the updated context
// rst_n clears valids and the context (idle, id zero, id unknown)
// out_stall holds the result; in_stall rises only when both stages are full
`default_nettype none

module floor_control_participant_fsm (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic        in_link_up,
  input  logic        in_floor_id_ok,
  input  logic        in_transport_err,
  input  logic [1:0]  in_prim_kind,
  input  logic        in_status_found,
  input  logic [15:0] in_msg_req_id,
  input  logic [2:0]  in_req_status,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_result_code,
  output logic [1:0]  out_send_kind,
  output logic [15:0] out_release_req_id,
  output logic        out_notify_valid,
  output logic        out_notify_granted,
  output logic [1:0]  out_floor_state_out
);
  import fcp_pkg::*;

  logic     evt_vld_r;
  fcp_evt_t evt_r;
  fcp_ctx_t ctx_r;
  fcp_ctx_t ctx_nxt;
  logic     res_vld_r;
  fcp_res_t res_r;
  fcp_res_t res_nxt;

  logic res_free;
  logic evt_move;
  logic in_xfer;

  assign res_free = !res_vld_r || !out_stall;
  assign evt_move = evt_vld_r && res_free;
  assign in_stall = evt_vld_r && !res_free;
  assign in_xfer  = in_valid && !in_stall;

  fcp_step u_step (
    .evt     (evt_r),
    .ctx     (ctx_r),
    .ctx_nxt (ctx_nxt),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      evt_vld_r <= 1'b0;
    end else if (in_xfer) begin
      evt_vld_r <= 1'b1;
    end else if (evt_move) begin
      evt_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      evt_r.cmd           <= cmd_t'(in_cmd);
      evt_r.link_up       <= in_link_up;
      evt_r.floor_id_ok   <= in_floor_id_ok;
      evt_r.transport_err <= in_transport_err;
      evt_r.prim_kind     <= prim_kind_t'(in_prim_kind);
      evt_r.status_found  <= in_status_found;
      evt_r.msg_req_id    <= in_msg_req_id;
      evt_r.req_status    <= req_status_t'(in_req_status);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r.fsm_st       <= ST_IDLE;
      ctx_r.held_req_id  <= '0;
      ctx_r.req_id_known <= 1'b0;
    end else if (evt_move) begin
      ctx_r <= ctx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (res_free) begin
      res_vld_r <= evt_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_move) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = res_vld_r;
  assign out_result_code     = res_r.result_code;
  assign out_send_kind       = res_r.send_kind;
  assign out_release_req_id  = res_r.release_req_id;
  assign out_notify_valid    = res_r.notify_valid;
  assign out_notify_granted  = res_r.notify_granted;
  assign out_floor_state_out = res_r.floor_state_out;

  // context only changes when an event is consumed
  a_ctx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !evt_move |=> $stable(ctx_r))
    else $error("floor context changed without an event");

  // the reported state is the context the next event will see
  a_state_track: assert property (@(posedge clk) disable iff (!rst_n)
    evt_move |=> (res_r.floor_state_out == ctx_r.fsm_st))
    else $error("reported state differs from context");

  a_grant_note: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_notify_granted) |-> out_notify_valid)
    else $error("granted without notification");

  a_release_sent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && res_r.send_kind == SEND_RELEASE)
      |-> (res_r.floor_state_out == ST_RELEASING && out_notify_valid))
    else $error("release sent without releasing state");

  a_request_sent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && res_r.send_kind == SEND_REQUEST)
      |-> (res_r.floor_state_out == ST_REQUESTING && res_r.result_code == RC_OK))
    else $error("request sent without requesting state");

endmodule

`default_nettype wire
